// ===== src/aps_pkg.sv =====
// ----------------------------------------------------------------------------
// aps_pkg
// Types, codes and helpers shared by the alarm panel sequencer modules.
// ----------------------------------------------------------------------------
package aps_pkg;

  localparam int CountW = 6;
  localparam int PhaseW = 3;
  localparam int ModeW  = 3;
  localparam int HoldW  = 4;
  localparam int DelayW = 6;

  localparam logic [CountW-1:0] CountMax  = 6'd63;
  localparam logic [PhaseW-1:0] PhaseLast = 3'd5;

  // register indexes on the configuration port
  localparam logic [1:0] RegHoldoff = 2'd0;
  localparam logic [1:0] RegArming  = 2'd1;
  localparam logic [1:0] RegEntry   = 2'd2;

  // mode codes as they appear on the result channel
  localparam logic [ModeW-1:0] CodeDisarmed  = 3'd0;
  localparam logic [ModeW-1:0] CodeArming    = 3'd1;
  localparam logic [ModeW-1:0] CodeArmed     = 3'd2;
  localparam logic [ModeW-1:0] CodeTriggered = 3'd3;
  localparam logic [ModeW-1:0] CodeSounding  = 3'd4;

  typedef enum logic [4:0] {
    MODE_DISARMED  = 5'b00001,
    MODE_ARMING    = 5'b00010,
    MODE_ARMED     = 5'b00100,
    MODE_TRIGGERED = 5'b01000,
    MODE_SOUNDING  = 5'b10000
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic              holdoff_done;
    logic [CountW-1:0] count;
    logic [PhaseW-1:0] phase;
    logic              status;
    logic              armed;
    logic              siren;
  } seq_state_t;

  typedef struct packed {
    logic [HoldW-1:0]  holdoff;
    logic [DelayW-1:0] arming;
    logic [DelayW-1:0] entry;
  } seq_cfg_t;

  function automatic logic [ModeW-1:0] mode_code(input mode_t m);
    logic [ModeW-1:0] c;
    case (m)
      MODE_DISARMED:  c = CodeDisarmed;
      MODE_ARMING:    c = CodeArming;
      MODE_ARMED:     c = CodeArmed;
      MODE_TRIGGERED: c = CodeTriggered;
      MODE_SOUNDING:  c = CodeSounding;
      default:        c = CodeDisarmed;
    endcase
    return c;
  endfunction

endpackage

// ===== src/aps_next.sv =====
// ----------------------------------------------------------------------------
// aps_next
// Next-state logic: seconds bookkeeping, mode transitions and lamp latches.
// ----------------------------------------------------------------------------
module aps_next import aps_pkg::*; (
  input  seq_state_t cur,
  input  seq_cfg_t   cfg,
  input  logic       button,
  input  logic       motion,
  input  logic       strobe,
  output seq_state_t nxt,
  output logic       notify
);

  logic [PhaseW-1:0] phase;
  logic [CountW-1:0] count;
  logic              even;
  logic              third;

  always_comb begin
    phase = cur.phase;
    count = cur.count;
    if (strobe) begin
      phase = (cur.phase >= PhaseLast) ? '0 : cur.phase + 1'b1;
      if (cur.count != CountMax) count = cur.count + 1'b1;
    end
    even  = ~phase[0];
    third = (phase == 3'd0) || (phase == 3'd3);
  end

  always_comb begin
    nxt       = cur;
    nxt.phase = phase;
    nxt.count = count;
    notify    = 1'b0;
    case (cur.mode)
      MODE_DISARMED: begin
        if (!cur.holdoff_done) begin
          if (count >= {2'b00, cfg.holdoff}) begin
            nxt.holdoff_done = 1'b1;
            nxt.status       = 1'b1;
            nxt.armed        = 1'b0;
          end
        end else if (button) begin
          nxt.mode  = MODE_ARMING;
          nxt.count = '0;
        end
      end
      MODE_ARMING: begin
        if (count >= cfg.arming) begin
          nxt.mode   = MODE_ARMED;
          nxt.status = 1'b0;
          nxt.armed  = 1'b1;
        end else begin
          nxt.status = even;
        end
      end
      MODE_ARMED: begin
        if (button) begin
          nxt.mode         = MODE_DISARMED;
          nxt.holdoff_done = 1'b0;
          nxt.count        = '0;
          nxt.siren        = 1'b0;
        end else if (motion) begin
          nxt.mode  = MODE_TRIGGERED;
          nxt.count = '0;
        end
      end
      MODE_TRIGGERED: begin
        if (button) begin
          nxt.mode         = MODE_DISARMED;
          nxt.holdoff_done = 1'b0;
          nxt.count        = '0;
          nxt.siren        = 1'b0;
        end else if (count >= cfg.entry) begin
          nxt.mode   = MODE_SOUNDING;
          nxt.count  = '0;
          notify     = 1'b1;
          nxt.status = third;
          nxt.armed  = third;
          nxt.siren  = third;
        end else begin
          nxt.status = even;
          nxt.armed  = even;
        end
      end
      MODE_SOUNDING: begin
        if (button) begin
          nxt.mode         = MODE_DISARMED;
          nxt.holdoff_done = 1'b0;
          nxt.count        = '0;
          nxt.siren        = 1'b0;
        end else begin
          nxt.status = third;
          nxt.armed  = third;
          nxt.siren  = third;
        end
      end
      default: begin
        nxt.mode         = MODE_DISARMED;
        nxt.holdoff_done = 1'b0;
        nxt.count        = '0;
        nxt.siren        = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/alarm_panel_sequencer.sv =====
// ----------------------------------------------------------------------------
// alarm_panel_sequencer
// Intruder-alarm mode sequencer with a registered result channel.
// ----------------------------------------------------------------------------
// Every accepted input transaction produces exactly one result transaction,
// showing the lamps, notify pulse and mode after that tick. One transaction
// can be taken every clock; the result appears in the output register in
// the cycle after acceptance. The input side stalls only while that register
// holds a result the consumer has not yet taken. Configuration writes take
// effect on the next accepted transaction.
module alarm_panel_sequencer import aps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [0] button_pressed, [1] motion_seen, [2] second_strobe
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] status_led, [1] armed_led, [2] siren,
                                 // [3] notify, [6:4] mode
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_wdata
);

  seq_state_t state_r;
  seq_state_t state_nxt;
  seq_cfg_t   cfg_r;
  logic       notify;
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       in_fire;

  assign in_tready = ~out_valid_r | out_tready;
  assign in_fire   = in_tvalid & in_tready;

  aps_next u_next (
    .cur    (state_r),
    .cfg    (cfg_r),
    .button (in_tdata[0]),
    .motion (in_tdata[1]),
    .strobe (in_tdata[2]),
    .nxt    (state_nxt),
    .notify (notify)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.holdoff <= 4'd1;
      cfg_r.arming  <= 6'd10;
      cfg_r.entry   <= 6'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        RegHoldoff: cfg_r.holdoff <= cfg_wdata[HoldW-1:0];
        RegArming:  cfg_r.arming  <= cfg_wdata;
        RegEntry:   cfg_r.entry   <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode         <= MODE_DISARMED;
      state_r.holdoff_done <= 1'b0;
      state_r.count        <= '0;
      state_r.phase        <= '0;
      state_r.status       <= 1'b0;
      state_r.armed        <= 1'b0;
      state_r.siren        <= 1'b0;
      out_valid_r          <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {1'b0, mode_code(state_nxt.mode), notify,
                     state_nxt.siren, state_nxt.armed, state_nxt.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the alarm panel sequencer. A short table of ticks
// walks every mode and the corner cases, then seven register settings each
// run biased random ticks. Every result is checked against an in-bench model
// of the panel, or the table's view for typed rows. Both stream sides idle at
// random, and once the result side stalls long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
  import aps_pkg::*;

  localparam logic [1:0] RegSpare    = 2'd3;  // not decoded, writes are dropped
  localparam int         CycleLimit  = 100000;
  localparam int         PressureAt  = 1200;
  localparam int         PressureLen = 60;
  localparam int         ShowLimit   = 40;

  // result item, status in bit 0
  typedef struct packed {
    logic             spare;
    logic [ModeW-1:0] mode;
    logic             notify;
    logic             siren;
    logic             armed;
    logic             status;
  } panel_view_t;

  // directed tick: bits are {strobe, motion, button}
  typedef struct packed {
    logic [2:0]  bits;
    logic        typed;
    panel_view_t view;
  } drill_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = 2'd0;
  logic [5:0] cfg_wdata = 6'd0;

  alarm_panel_sequencer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // panel model state and its copy of the registers
  logic [ModeW-1:0]  pm_mode;
  logic              pm_hold_done;
  logic [CountW-1:0] pm_count;
  logic [PhaseW-1:0] pm_phase;
  logic              pm_status, pm_armed, pm_siren;
  logic [HoldW-1:0]  rg_holdoff;
  logic [DelayW-1:0] rg_arming, rg_entry;

  panel_view_t expected_views[$];
  drill_row_t  drill_rows [0:25];
  int          fail_count = 0;
  int          ticks_sent = 0;
  int          results_seen = 0;
  int          soundings = 0;
  int          mode_hits [0:4] = '{0, 0, 0, 0, 0};
  int          cycle_count = 0;
  int          hold_left = 0;
  logic        pressure_done = 1'b0;
  logic        steady = 1'b0;

  function automatic void disarm_panel();
    pm_mode      = CodeDisarmed;
    pm_hold_done = 1'b0;
    pm_count     = '0;
    pm_siren     = 1'b0;
  endfunction

  function automatic panel_view_t advance_panel(input logic [2:0] bits);
    panel_view_t v;
    logic        btn, mot, even, third, pulse;
    btn   = bits[0];
    mot   = bits[1];
    pulse = 1'b0;
    if (bits[2]) begin
      pm_phase = (pm_phase >= PhaseLast) ? '0 : pm_phase + 1'b1;
      if (pm_count < CountMax) pm_count = pm_count + 1'b1;
    end
    even  = ~pm_phase[0];
    third = (pm_phase % 3'd3) == 3'd0;
    case (pm_mode)
      CodeDisarmed: begin
        // button is only read on ticks after the hold-off has ended
        if (!pm_hold_done) begin
          if (pm_count >= rg_holdoff) begin
            pm_hold_done = 1'b1;
            pm_status    = 1'b1;
            pm_armed     = 1'b0;
          end
        end else if (btn) begin
          pm_mode  = CodeArming;
          pm_count = '0;
        end
      end
      CodeArming: begin
        if (pm_count >= rg_arming) begin
          pm_mode   = CodeArmed;
          pm_status = 1'b0;
          pm_armed  = 1'b1;
        end else begin
          pm_status = even;
        end
      end
      CodeArmed: begin
        if (btn) disarm_panel();
        else if (mot) begin
          pm_mode  = CodeTriggered;
          pm_count = '0;
        end
      end
      CodeTriggered: begin
        if (btn) disarm_panel();
        else if (pm_count >= rg_entry) begin
          pm_mode  = CodeSounding;
          pm_count = '0;
          pulse    = 1'b1;
          {pm_status, pm_armed, pm_siren} = {3{third}};
        end else begin
          pm_status = even;
          pm_armed  = even;
        end
      end
      CodeSounding: begin
        if (btn) disarm_panel();
        else {pm_status, pm_armed, pm_siren} = {3{third}};
      end
      default: disarm_panel();
    endcase
    v.spare  = 1'b0;
    v.mode   = pm_mode;
    v.notify = pulse;
    v.siren  = pm_siren;
    v.armed  = pm_armed;
    v.status = pm_status;
    return v;
  endfunction

  // random tick, leaning toward what moves the panel out of its current mode
  function automatic logic [2:0] pick_inputs(input int strobe_pct);
    int btn_pct, mot_pct;
    if ($urandom_range(99) < 15) return 3'($urandom_range(7));
    case (pm_mode)
      CodeDisarmed:  begin btn_pct = pm_hold_done ? 40 : 30; mot_pct = 20; end
      CodeArming:    begin btn_pct = 30; mot_pct = 30; end
      CodeArmed:     begin btn_pct = 2;  mot_pct = 15; end
      CodeTriggered: begin btn_pct = 1;  mot_pct = 50; end
      default:       begin btn_pct = 2;  mot_pct = 50; end
    endcase
    return {$urandom_range(99) < strobe_pct, $urandom_range(99) < mot_pct,
            $urandom_range(99) < btn_pct};
  endfunction

  task automatic flag_mismatch(input string what, input int want_v, input int got_v);
    if (fail_count < ShowLimit)
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want_v, got_v);
    fail_count++;
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [5:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      RegHoldoff: rg_holdoff = val[HoldW-1:0];
      RegArming:  rg_arming  = val;
      RegEntry:   rg_entry   = val;
      default: ;
    endcase
  endtask

  task automatic push_tick(input logic [2:0] bits, input logic typed,
                           input panel_view_t view);
    panel_view_t want;
    while (!steady && $urandom_range(99) < 14) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b00000, bits};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = advance_panel(bits);
    expected_views.push_back(typed ? view : want);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    while (expected_views.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic run_phase(input logic [5:0] hold_w, input logic [5:0] arm_w,
                           input logic [5:0] entry_w, input int count,
                           input int strobe_pct, input logic quiet);
    settle();
    @(posedge clk);
    steady = quiet;
    @(negedge clk);
    write_register(RegHoldoff, hold_w);
    write_register(RegArming, arm_w);
    write_register(RegEntry, entry_w);
    cfg_we <= 1'b0;
    for (int n = 0; n < count; n++) push_tick(pick_inputs(strobe_pct), 1'b0, '0);
    in_tvalid <= 1'b0;
  endtask

  // result side: random stalls, plus one long hold-off to back up the input
  always @(negedge clk) begin
    if (!pressure_done && ticks_sent >= PressureAt) begin
      hold_left     = PressureLen;
      pressure_done = 1'b1;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    panel_view_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_views.size() == 0) begin
        flag_mismatch("unexpected result transaction", 0, got);
      end else begin
        want = expected_views.pop_front();
        results_seen++;
        if (want.notify) soundings++;
        if (want.mode <= CodeSounding) mode_hits[want.mode]++;
        if (got.status !== want.status) flag_mismatch("status_led", want.status, got.status);
        if (got.armed !== want.armed)   flag_mismatch("armed_led", want.armed, got.armed);
        if (got.siren !== want.siren)   flag_mismatch("siren", want.siren, got.siren);
        if (got.notify !== want.notify) flag_mismatch("notify", want.notify, got.notify);
        if (got.mode !== want.mode)     flag_mismatch("mode", want.mode, got.mode);
        if (got.spare !== want.spare)   flag_mismatch("tdata pad bit", want.spare, got.spare);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    // with holdoff 1, arming 2, entry 1: one lap through all modes, then
    // disarm from armed and from triggered
    drill_rows = '{
      '{3'b000, 1'b1, 8'h00},  // first tick after reset: dark and disarmed
      '{3'b011, 1'b1, 8'h00},  // button during hold-off is ignored
      '{3'b100, 1'b0, 8'h00},  // hold-off ends
      '{3'b010, 1'b0, 8'h00},
      '{3'b001, 1'b0, 8'h00},  // arm
      '{3'b100, 1'b0, 8'h00},
      '{3'b100, 1'b0, 8'h00},  // exit delay done
      '{3'b100, 1'b0, 8'h00},
      '{3'b010, 1'b0, 8'h00},  // motion triggers
      '{3'b000, 1'b0, 8'h00},
      '{3'b110, 1'b0, 8'h00},  // entry delay runs out: notify
      '{3'b100, 1'b0, 8'h00},  // phase wraps to zero, all on
      '{3'b010, 1'b0, 8'h00},
      '{3'b001, 1'b0, 8'h00},  // disarm from sounding drops the siren only
      '{3'b101, 1'b0, 8'h00},  // hold-off ends, button not read yet
      '{3'b111, 1'b0, 8'h00},
      '{3'b011, 1'b0, 8'h00},
      '{3'b100, 1'b0, 8'h00},
      '{3'b100, 1'b0, 8'h00},
      '{3'b011, 1'b0, 8'h00},  // button wins over motion when armed
      '{3'b100, 1'b0, 8'h00},
      '{3'b001, 1'b0, 8'h00},
      '{3'b100, 1'b0, 8'h00},
      '{3'b100, 1'b0, 8'h00},
      '{3'b010, 1'b0, 8'h00},
      '{3'b111, 1'b0, 8'h00}   // disarm from triggered
    };
    pm_mode      = CodeDisarmed;
    pm_hold_done = 1'b0;
    pm_count     = '0;
    pm_phase     = '0;
    {pm_status, pm_armed, pm_siren} = 3'b000;
    rg_holdoff = 4'd1;
    rg_arming  = 6'd10;
    rg_entry   = 6'd10;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_register(RegHoldoff, 6'd1);
    write_register(RegArming, 6'd2);
    write_register(RegEntry, 6'd1);
    write_register(RegSpare, 6'h2A);
    cfg_we <= 1'b0;
    foreach (drill_rows[i])
      push_tick(drill_rows[i].bits, drill_rows[i].typed, drill_rows[i].view);
    in_tvalid <= 1'b0;

    run_phase(6'd1, 6'd10, 6'd10, 300, 45, 1'b0);
    run_phase(6'd1, 6'd1, 6'd1, 250, 45, 1'b1);
    run_phase(6'd15, 6'd60, 6'd60, 450, 90, 1'b0);
    run_phase(6'd0, 6'd0, 6'd0, 200, 45, 1'b0);
    run_phase(6'h3F, 6'd3, 6'd2, 200, 30, 1'b0);
    run_phase(6'($urandom_range(1, 15)), 6'($urandom_range(1, 8)),
              6'($urandom_range(1, 8)), 250, 45, 1'b0);
    run_phase(6'($urandom_range(1, 15)), 6'($urandom_range(1, 20)),
              6'($urandom_range(1, 20)), 250, 60, 1'b0);

    settle();
    $display("Checked %0d results over 8 register settings, %0d alarm soundings entered.",
             results_seen, soundings);
    $display("Ticks per mode: disarmed %0d, arming %0d, armed %0d, triggered %0d, sounding %0d",
             mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4]);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
